@@ rtl/core/tcw_pkg.sv @@
// Shared constants, types and command encoding for the text console writer.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

    localparam int ROWS   = 25;
    localparam int COLS   = 80;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] BLANK_CHAR  = 8'h20;
    localparam logic [BYTE_W-1:0] RESET_COLOR = 8'd15;
    localparam int               QUEUE_DEPTH = 2;
    localparam int               QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_NEWLINE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_FILL,
        S_SCROLL
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] color;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
        logic              read_ok;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

endpackage

@@ rtl/core/tcw_if.sv @@
// Channel interfaces of the text console writer: request, result and fill color.
// Depends on tcw_pkg for the field widths.
interface tcw_req_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] color;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;

    modport source (output valid, req_type, char_code, color, read_row, read_col,
                    input ready);
    modport sink   (input valid, req_type, char_code, color, read_row, read_col,
                    output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;

    modport source (output valid, cursor_row, cursor_col, cell_data, scrolled,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_col, cell_data, scrolled,
                    output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/tcw_front.sv @@
// Front end: accepts requests, decodes them into commands and holds them in a
// two-entry queue for the back end. Depends on tcw_pkg and tcw_if.
module tcw_front import tcw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_req_if.sink     i_req,
    input  logic        i_init_busy,
    input  logic        i_pop,
    output t_queue_head o_head
);

    t_cmd                r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QPTR_W:0]     n_count;
    logic                push;
    logic                pop;
    t_cmd                dec;

    always_comb begin
        dec.op        = t_op'(i_req.req_type);
        dec.char_code = i_req.char_code;
        dec.color     = i_req.color;
        dec.read_row  = i_req.read_row;
        dec.read_col  = i_req.read_col;
        dec.read_ok   = (32'(i_req.read_row) < 32'(ROWS)) &&
                        (32'(i_req.read_col) < 32'(COLS));
    end

    assign i_req.ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH)) && !i_init_busy;
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

endmodule

@@ rtl/core/tcw_back.sv @@
// Back end: cursor, screen store and the sequencer that carries out commands,
// including the reset sweep, clear sweep and one-row scroll. Depends on tcw_pkg
// and tcw_if.
module tcw_back import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_queue_head       i_head,
    input  logic [BYTE_W-1:0] i_fill_color,
    output logic              o_pop,
    output logic              o_init_busy,
    tcw_res_if.source         o_res
);

    // The store is a ring of rows: r_top is the physical row shown as row 0,
    // so a scroll only rewrites one row and moves r_top.
    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_top, n_top;
    logic [ADDR_W-1:0] r_cnt, n_cnt;

    logic              r_res_valid, n_res_valid;
    logic [ROW_W-1:0]  r_res_row;
    logic [COL_W-1:0]  r_res_col;
    logic [CELL_W-1:0] r_res_data;
    logic              r_res_scrolled;

    logic              res_load;
    logic [CELL_W-1:0] res_data;
    logic              res_scrolled;
    logic              slot_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] top_base;
    t_cmd              cmd;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

    assign cmd       = i_head.cmd;
    assign slot_free = !r_res_valid || o_res.ready;
    assign cur_addr  = cell_addr(phys_row(r_row, r_top), r_col);
    assign rd_addr   = cell_addr(phys_row(cmd.read_row, r_top), cmd.read_col);
    assign top_base  = cell_addr(r_top, '0);

    assign o_init_busy      = (r_state == S_INIT);
    assign o_res.valid      = r_res_valid;
    assign o_res.cursor_row = r_res_row;
    assign o_res.cursor_col = r_res_col;
    assign o_res.cell_data  = r_res_data;
    assign o_res.scrolled   = r_res_scrolled;

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_top        = r_top;
        n_cnt        = r_cnt;
        o_pop        = 1'b0;
        res_load     = 1'b0;
        res_data     = '0;
        res_scrolled = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_cnt;
        mem_wdata    = {RESET_COLOR, BLANK_CHAR};
        mem_re       = 1'b0;
        mem_raddr    = rd_addr;

        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_head.valid && slot_free) begin
                    o_pop = 1'b1;
                    unique case (cmd.op)
                        OP_WRITE, OP_NEWLINE: begin
                            if (cmd.op == OP_WRITE) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {cmd.color, cmd.char_code};
                            end
                            if (cmd.op == OP_WRITE && r_col != COL_W'(COLS - 1)) begin
                                n_col    = r_col + 1'b1;
                                res_load = 1'b1;
                            end else begin
                                n_col = '0;
                                if (r_row == ROW_W'(ROWS - 1)) begin
                                    n_state = S_SCROLL;
                                    n_cnt   = '0;
                                end else begin
                                    n_row    = r_row + 1'b1;
                                    res_load = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            n_state = S_FILL;
                            n_cnt   = '0;
                        end
                        OP_READ: begin
                            if (cmd.read_ok) begin
                                mem_re  = 1'b1;
                                n_state = S_READ;
                            end else begin
                                res_load = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                res_load = 1'b1;
                res_data = r_rdata;
                n_state  = S_IDLE;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = {i_fill_color, BLANK_CHAR};
                if (r_cnt == ADDR_W'(CELLS - 1)) begin
                    n_state  = S_IDLE;
                    n_cnt    = '0;
                    n_row    = '0;
                    n_col    = '0;
                    n_top    = '0;
                    res_load = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SCROLL: begin
                // The old top row becomes the new blank bottom row.
                mem_we    = 1'b1;
                mem_waddr = top_base + r_cnt;
                mem_wdata = {i_fill_color, BLANK_CHAR};
                if (r_cnt == ADDR_W'(COLS - 1)) begin
                    n_state      = S_IDLE;
                    n_cnt        = '0;
                    n_top        = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
                    res_load     = 1'b1;
                    res_scrolled = 1'b1;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res_valid = res_load ? 1'b1 : (o_res.ready ? 1'b0 : r_res_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_top       <= n_top;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_row      <= n_row;
            r_res_col      <= n_col;
            r_res_data     <= res_data;
            r_res_scrolled <= res_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer: 25 x 80 cell store with cursor, newline, clear and read.
// Results: a write or newline result passes the command queue and the result register; a read
// also passes the store's read register; a scroll first writes each column of the new bottom row
// and a clear each cell. Throughput: a write or newline every cycle when no sweep runs and
// results are taken; a read holds the sequencer until its result is loaded. Reset: synchronous;
// a sweep blanks the store in color 15, no request taken. Depends on tcw_pkg, tcw_if, tcw_front and tcw_back.
module text_console_writer import tcw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_req_if.sink   i_req,
    tcw_cfg_if.sink   i_cfg,
    tcw_res_if.source o_res
);

    logic [BYTE_W-1:0] r_fill_color;
    t_queue_head       head;
    logic              pop;
    logic              init_busy;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_color <= RESET_COLOR;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_fill_color <= i_cfg.data;
        end
    end

    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_init_busy (init_busy),
        .i_pop       (pop),
        .o_head      (head)
    );

    tcw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_fill_color (r_fill_color),
        .o_pop        (pop),
        .o_init_busy  (init_busy),
        .o_res        (o_res)
    );

endmodule

@@ sim/text_console_writer_tb.sv @@
// Self-checking testbench for text_console_writer: directed table, then random phases.
// Depends on tcw_pkg, the tcw_*_if interfaces and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int WATCHDOG_CYCLES = 12000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 100;
    localparam int PHASE_ITEMS     = 95;
    localparam int NUM_PHASES      = 4;
    localparam int MAX_PRINTED     = 20;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] char_code;
        logic [BYTE_W-1:0] color;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_req;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } t_res;

    typedef struct {
        t_req item;
        int   rep;
        bit   has_exp;
        t_res exp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    tcw_req_if req_if();
    tcw_res_if res_if();
    tcw_cfg_if cfg_if();

    text_console_writer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Console model state.
    logic [CELL_W-1:0] screen [CELLS];
    int                cur_row;
    int                cur_col;
    logic [BYTE_W-1:0] fill_color;

    t_res awaited_results[$];
    int   mismatches   = 0;
    int   results_seen = 0;
    int   idle_cycles  = 0;
    bit   gaps_on;
    bit   hold_req;

    // Rows without a typed result are checked against the console model. The block of
    // writes on the bottom row fills it with 'A' in color 1E, and the last one scrolls.
    t_dir_row dir_rows [22] = '{
        '{'{OP_READ,    8'h00, 8'h00, 5'd0,  7'd0},   1,  1'b1, '{5'd0,  7'd0, 16'h0F20, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd24, 7'd79},  1,  1'b1, '{5'd0,  7'd0, 16'h0F20, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd25, 7'd0},   1,  1'b1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd0,  7'd80},  1,  1'b1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd31, 7'd127}, 1,  1'b1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
        '{'{OP_WRITE,   8'hFF, 8'hFF, 5'd31, 7'd127}, 1,  1'b1, '{5'd0,  7'd1, 16'h0000, 1'b0}},
        '{'{OP_WRITE,   8'h00, 8'h00, 5'd0,  7'd0},   1,  1'b1, '{5'd0,  7'd2, 16'h0000, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd0,  7'd0},   1,  1'b1, '{5'd0,  7'd2, 16'hFFFF, 1'b0}},
        '{'{OP_READ,    8'hFF, 8'hFF, 5'd0,  7'd1},   1,  1'b1, '{5'd0,  7'd2, 16'h0000, 1'b0}},
        '{'{OP_NEWLINE, 8'h00, 8'h00, 5'd0,  7'd0},   1,  1'b1, '{5'd1,  7'd0, 16'h0000, 1'b0}},
        '{'{OP_CLEAR,   8'hFF, 8'hFF, 5'd31, 7'd127}, 1,  1'b1, '{5'd0,  7'd0, 16'h0000, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd0,  7'd0},   1,  1'b1, '{5'd0,  7'd0, 16'hA520, 1'b0}},
        '{'{OP_NEWLINE, 8'h00, 8'h00, 5'd0,  7'd0},   23, 1'b0, '{5'd0,  7'd0, 16'h0000, 1'b0}},
        '{'{OP_NEWLINE, 8'h00, 8'h00, 5'd0,  7'd0},   1,  1'b1, '{5'd24, 7'd0, 16'h0000, 1'b0}},
        '{'{OP_WRITE,   8'h41, 8'h1E, 5'd0,  7'd0},   79, 1'b0, '{5'd0,  7'd0, 16'h0000, 1'b0}},
        '{'{OP_WRITE,   8'h41, 8'h1E, 5'd0,  7'd0},   1,  1'b1, '{5'd24, 7'd0, 16'h0000, 1'b1}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd23, 7'd0},   1,  1'b1, '{5'd24, 7'd0, 16'h1E41, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd24, 7'd0},   1,  1'b1, '{5'd24, 7'd0, 16'hA520, 1'b0}},
        '{'{OP_NEWLINE, 8'h00, 8'h00, 5'd0,  7'd0},   1,  1'b1, '{5'd24, 7'd0, 16'h0000, 1'b1}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd22, 7'd79},  1,  1'b1, '{5'd24, 7'd0, 16'h1E41, 1'b0}},
        '{'{OP_READ,    8'h00, 8'h00, 5'd23, 7'd40},  1,  1'b1, '{5'd24, 7'd0, 16'hA520, 1'b0}},
        '{'{OP_CLEAR,   8'h00, 8'h00, 5'd0,  7'd0},   1,  1'b1, '{5'd0,  7'd0, 16'h0000, 1'b0}}
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_error(input string text);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("%0t ns: %s", $realtime, text);
        end
    endtask

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen[i] = {fill_color, BLANK_CHAR};
        end
    endfunction

    // Moves the cursor down one row; at the bottom the screen scrolls instead.
    function automatic logic advance_row();
        cur_row++;
        if (cur_row < ROWS) begin
            return 1'b0;
        end
        for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
            screen[i] = screen[i + COLS];
        end
        for (int x = 0; x < COLS; x++) begin
            screen[(ROWS - 1) * COLS + x] = {fill_color, BLANK_CHAR};
        end
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic t_res console_step(input t_req r);
        t_res res;
        res = '0;
        case (r.op)
            OP_WRITE: begin
                screen[cur_row * COLS + cur_col] = {r.color, r.char_code};
                cur_col++;
                if (cur_col >= COLS) begin
                    cur_col = 0;
                    res.scrolled = advance_row();
                end
            end
            OP_NEWLINE: begin
                cur_col = 0;
                res.scrolled = advance_row();
            end
            OP_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            default: begin
                if (r.read_row < ROWS && r.read_col < COLS) begin
                    res.cell_data = screen[r.read_row * COLS + r.read_col];
                end
            end
        endcase
        res.cursor_row = ROW_W'(cur_row);
        res.cursor_col = COL_W'(cur_col);
        return res;
    endfunction

    // Reads land near the cursor, where recent writes are, half the time, else anywhere on
    // the screen, and sometimes anywhere in the field range, out of the screen included.
    function automatic t_req random_req(input int newline_pct);
        t_req r;
        int   pick;
        int   aim;
        r.char_code = BYTE_W'($urandom);
        r.color     = BYTE_W'($urandom);
        r.read_row  = ROW_W'($urandom);
        r.read_col  = COL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            r.op = OP_CLEAR;
        end else if (pick < 28) begin
            r.op = OP_READ;
            aim = $urandom_range(0, 9);
            if (aim < 5) begin
                r.read_row = ROW_W'((cur_row > 0 && aim[0]) ? cur_row - 1 : cur_row);
                r.read_col = COL_W'($urandom_range(0, COLS - 1));
            end else if (aim < 8) begin
                r.read_row = ROW_W'($urandom_range(0, ROWS - 1));
                r.read_col = COL_W'($urandom_range(0, COLS - 1));
            end
        end else if (pick < 28 + newline_pct) begin
            r.op = OP_NEWLINE;
        end else begin
            r.op = OP_WRITE;
        end
        return r;
    endfunction

    task automatic send_request(input t_req r, input bit has_exp, input t_res exp);
        t_res predicted;
        if (gaps_on && $urandom_range(0, 99) < 15) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= r.op;
        req_if.char_code <= r.char_code;
        req_if.color     <= r.color;
        req_if.read_row  <= r.read_row;
        req_if.read_col  <= r.read_col;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = console_step(r);
        awaited_results.push_back(has_exp ? exp : predicted);
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_fill_color(input logic [BYTE_W-1:0] value);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        fill_color = value;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_ready
        bit held;
        held = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_if.ready <= !(gaps_on && $urandom_range(0, 99) < 15);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing outstanding",
                                       results_seen));
            end else begin
                want = awaited_results.pop_front();
                if (res_if.cursor_row !== want.cursor_row)
                    report_error($sformatf("result %0d: cursor_row %0d, expected %0d",
                                           results_seen, res_if.cursor_row, want.cursor_row));
                if (res_if.cursor_col !== want.cursor_col)
                    report_error($sformatf("result %0d: cursor_col %0d, expected %0d",
                                           results_seen, res_if.cursor_col, want.cursor_col));
                if (res_if.cell_data !== want.cell_data)
                    report_error($sformatf("result %0d: cell_data %h, expected %h",
                                           results_seen, res_if.cell_data, want.cell_data));
                if (res_if.scrolled !== want.scrolled)
                    report_error($sformatf("result %0d: scrolled %b, expected %b",
                                           results_seen, res_if.scrolled, want.scrolled));
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int newline_pct;
        t_req r;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = OP_WRITE;
        req_if.char_code = '0;
        req_if.color     = '0;
        req_if.read_row  = '0;
        req_if.read_col  = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        gaps_on          = 1'b1;
        hold_req         = 1'b0;
        fill_color       = RESET_COLOR;
        cur_row          = 0;
        cur_col          = 0;
        blank_screen();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_fill_color(8'hA5);
        foreach (dir_rows[k]) begin
            repeat (dir_rows[k].rep) begin
                send_request(dir_rows[k].item, dir_rows[k].has_exp, dir_rows[k].exp);
            end
        end
        req_if.valid <= 1'b0;

        // Phase 1 runs with no stalls on either side; phase 2 carries the long hold-off.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    write_fill_color(8'h00);
                    newline_pct = 15;
                end
                1: begin
                    write_fill_color(8'hFF);
                    newline_pct = 3;
                end
                2: begin
                    write_fill_color(BYTE_W'($urandom_range(0, 255)));
                    newline_pct = 10;
                end
                default: begin
                    write_fill_color(BYTE_W'($urandom_range(0, 255)));
                    newline_pct = 20;
                end
            endcase
            gaps_on  = (p != 1);
            hold_req = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = random_req(newline_pct);
                send_request(r, 1'b0, '0);
            end
            req_if.valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ text_console_writer.f @@
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_front.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
sim/text_console_writer_tb.sv
